>>> src/hfr_pkg.sv
// Shared types and constants of the length-prefixed frame receiver.
`default_nettype none
package hfr_pkg;

  // Fixed field widths.
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 16;
  localparam int PLEN_W    = 6;
  localparam int PIDX_W    = 5;
  localparam int CFG_IDX_W = 2;

  // Length byte counts type and two command bytes ahead of the payload.
  localparam int MIN_LEN = 3;

  // Reset value of the header register.
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_DELIVER = 2'd1
  } cfg_reg_t;

  // Sequencer states: three parse phases, then the emit loop.
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_FETCH,
    ST_LOAD,
    ST_HOLD
  } state_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic hdr_match;
    logic len_ok;
    logic count_done;
    logic check_ok;
    logic out_last;
  } hfr_stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic take_len;
    logic take_data;
    logic start_emit;
    logic load_out;
    logic out_done;
  } hfr_ctrl_t;

endpackage
`default_nettype wire

>>> src/hfr_if.sv
// Valid/ready channel interfaces: received bytes, result items, configuration writes.
`default_nettype none
interface hfr_rx_if;
  logic                      valid;
  logic                      ready;
  logic [hfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hfr_res_if;
  logic                        valid;
  logic                        ready;
  logic [hfr_pkg::BYTE_W-1:0]  frame_type;
  logic [hfr_pkg::CMD_W-1:0]   command;
  logic [hfr_pkg::PLEN_W-1:0]  payload_len;
  logic                        has_payload;
  logic [hfr_pkg::PIDX_W-1:0]  payload_index;
  logic [hfr_pkg::BYTE_W-1:0]  payload_byte;
  logic                        last;

  modport source (output valid, output frame_type, output command, output payload_len,
                  output has_payload, output payload_index, output payload_byte,
                  output last, input ready);
  modport sink   (input valid, input frame_type, input command, input payload_len,
                  input has_payload, input payload_index, input payload_byte,
                  input last, output ready);
endinterface

interface hfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hfr_pkg::CFG_IDX_W-1:0] reg_index;
  logic [hfr_pkg::BYTE_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

>>> src/hfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/hfr_seq.sv
// Sequencer of the frame receiver: parse phases and the result emit loop.
`default_nettype none
module hfr_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rx_valid,
  output logic                    rx_ready,
  output logic                    res_valid,
  input  wire logic               res_ready,
  input  wire hfr_pkg::hfr_stat_t stat,
  output hfr_pkg::hfr_ctrl_t      ctrl
);
  import hfr_pkg::*;

  state_t state;
  state_t state_next;
  logic   rx_fire;
  logic   res_fire;

  assign rx_fire  = rx_valid && rx_ready;
  assign res_fire = res_valid && res_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_HUNT: begin
        if (rx_fire && stat.hdr_match) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (rx_fire) state_next = stat.len_ok ? ST_DATA : ST_HUNT;
      end
      ST_DATA: begin
        if (rx_fire && stat.count_done) begin
          state_next = stat.check_ok ? ST_FETCH : ST_HUNT;
        end
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_HOLD;
      ST_HOLD: begin
        if (res_fire) state_next = stat.out_last ? ST_HUNT : ST_FETCH;
      end
      default: state_next = ST_HUNT;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    rx_ready  = 1'b0;
    res_valid = 1'b0;
    ctrl      = '0;
    case (state)
      ST_HUNT: rx_ready = 1'b1;
      ST_LEN: begin
        rx_ready      = 1'b1;
        ctrl.take_len = rx_fire;
      end
      ST_DATA: begin
        rx_ready        = 1'b1;
        ctrl.take_data  = rx_fire && !stat.count_done;
        ctrl.start_emit = rx_fire && stat.count_done;
      end
      ST_FETCH: ;
      ST_LOAD:  ctrl.load_out = 1'b1;
      ST_HOLD: begin
        res_valid     = 1'b1;
        ctrl.out_done = res_fire;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/hfr_dp.sv
// Datapath of the frame receiver: config registers, frame fields, running XOR, result register.
`default_nettype none
module hfr_dp #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int CNT_W       = $clog2(MAX_PAYLOAD + hfr_pkg::MIN_LEN + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  hfr_cfg_if.sink                          cfg,
  input  wire logic [hfr_pkg::BYTE_W-1:0]  rx_byte,
  input  wire hfr_pkg::hfr_ctrl_t          ctrl,
  output hfr_pkg::hfr_stat_t               stat,
  output logic                             ram_we,
  output logic      [AW-1:0]               ram_waddr,
  output logic      [AW-1:0]               ram_raddr,
  input  wire logic [hfr_pkg::BYTE_W-1:0]  ram_rdata,
  output logic      [hfr_pkg::BYTE_W-1:0]  frame_type,
  output logic      [hfr_pkg::CMD_W-1:0]   command,
  output logic      [hfr_pkg::PLEN_W-1:0]  payload_len,
  output logic                             has_payload,
  output logic      [hfr_pkg::PIDX_W-1:0]  payload_index,
  output logic      [hfr_pkg::BYTE_W-1:0]  payload_byte,
  output logic                             last
);
  import hfr_pkg::*;

  logic [BYTE_W-1:0] header_byte;
  logic              deliver_enable;
  logic [CNT_W-1:0]  length_field;
  logic [CNT_W-1:0]  byte_count;
  logic [BYTE_W-1:0] running_xor;
  logic [BYTE_W-1:0] type_reg;
  logic [CMD_W-1:0]  command_reg;
  logic [CNT_W-1:0]  emit_idx;
  logic [CNT_W-1:0]  plen;
  logic [CNT_W-1:0]  store_idx;
  logic              plen_zero;

  // Configuration writes are always taken; unknown indexes are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte    <= HEADER_RESET;
      deliver_enable <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_HEADER:  header_byte    <= cfg.wdata;
        CFG_DELIVER: deliver_enable <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // Payload length and store positions.
  assign plen      = length_field - CNT_W'(MIN_LEN);
  assign plen_zero = (plen == '0);
  assign store_idx = byte_count - CNT_W'(MIN_LEN);

  // Status toward the sequencer.
  always_comb begin
    stat.hdr_match  = (rx_byte == header_byte);
    stat.len_ok     = (rx_byte >= BYTE_W'(MIN_LEN)) &&
                      (rx_byte <= BYTE_W'(MAX_PAYLOAD + MIN_LEN));
    stat.count_done = (byte_count >= length_field);
    stat.check_ok   = (rx_byte == running_xor) && deliver_enable;
    stat.out_last   = last;
  end

  // Payload bytes go to the store; the emit index reads it back.
  assign ram_we    = ctrl.take_data && (byte_count >= CNT_W'(MIN_LEN));
  assign ram_waddr = store_idx[AW-1:0];
  assign ram_raddr = emit_idx[AW-1:0];

  // Frame parsing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_field <= '0;
      byte_count   <= '0;
      running_xor  <= '0;
      type_reg     <= '0;
      command_reg  <= '0;
      emit_idx     <= '0;
    end else begin
      if (ctrl.take_len) begin
        length_field <= rx_byte[CNT_W-1:0];
        byte_count   <= '0;
        running_xor  <= rx_byte;
      end
      if (ctrl.take_data) begin
        case (byte_count)
          CNT_W'(0): type_reg                   <= rx_byte;
          CNT_W'(1): command_reg[CMD_W-1:BYTE_W] <= rx_byte;
          CNT_W'(2): command_reg[BYTE_W-1:0]     <= rx_byte;
          default: ;
        endcase
        running_xor <= running_xor ^ rx_byte;
        byte_count  <= byte_count + 1'b1;
      end
      if (ctrl.start_emit) begin
        emit_idx <= '0;
      end else if (ctrl.out_done) begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

  // Result register, loaded from the registered store read data.
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      frame_type    <= type_reg;
      command       <= command_reg;
      payload_len   <= PLEN_W'(plen);
      has_payload   <= !plen_zero;
      payload_index <= PIDX_W'(emit_idx);
      payload_byte  <= plen_zero ? '0 : ram_rdata;
      last          <= plen_zero || ((emit_idx + 1'b1) == plen);
    end
  end

endmodule
`default_nettype wire

>>> src/hex_frame_receiver_xor_check.sv
// While the block hunts for a header or parses a frame, rx.ready is high and each offered byte is taken.
// After a good check byte with delivery enabled, each result passes through the
// store read (FETCH), load (LOAD) and hold (HOLD) states and stays valid in HOLD until
// the sink takes it; no byte is taken until the last result of the frame is gone.
// Reset (synchronous, active high) returns to hunting with header 0x55, delivery off.
`default_nettype none
module hex_frame_receiver_xor_check #(
  parameter int MAX_PAYLOAD = 32
) (
  input wire logic clk,
  input wire logic rst,
  hfr_rx_if.sink   rx,
  hfr_res_if.source res,
  hfr_cfg_if.sink  cfg
);
  import hfr_pkg::*;

  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W = $clog2(MAX_PAYLOAD + MIN_LEN + 1);

  hfr_stat_t         stat;
  hfr_ctrl_t         ctrl;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Sequencer.
  hfr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Datapath.
  hfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .rx_byte       (rx.rx_byte),
    .ctrl          (ctrl),
    .stat          (stat),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .frame_type    (res.frame_type),
    .command       (res.command),
    .payload_len   (res.payload_len),
    .has_payload   (res.has_payload),
    .payload_index (res.payload_index),
    .payload_byte  (res.payload_byte),
    .last          (res.last)
  );

  // Payload store.
  hfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

>>> dv/tb_hex_frame_receiver_xor_check.sv
// Self-checking testbench for the length-prefixed frame receiver with XOR check.
module tb_hex_frame_receiver_xor_check;
  timeunit 1ns;
  timeprecision 1ps;

  import hfr_pkg::*;

  localparam int MAX_PAYLOAD   = 32;
  localparam int MAX_LEN       = MAX_PAYLOAD + MIN_LEN;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef logic [BYTE_W-1:0] byte_t;

  // Parse phases tracked by the predictor.
  typedef enum logic [1:0] {
    PARSE_HUNT,
    PARSE_LEN,
    PARSE_DATA
  } parse_t;

  // How the data bytes of a frame are filled.
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  // One result item as the block should deliver it.
  typedef struct packed {
    byte_t             frame_type;
    logic [CMD_W-1:0]  command;
    logic [PLEN_W-1:0] payload_len;
    logic              has_payload;
    logic [PIDX_W-1:0] payload_index;
    byte_t             payload_byte;
    logic              last;
  } frame_item_t;

  logic clk = 1'b0;
  logic rst;

  hfr_rx_if  rx_ch ();
  hfr_res_if res_ch ();
  hfr_cfg_if cfg_ch ();

  hex_frame_receiver_xor_check #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always #10 clk = ~clk;

  // Predictor copy of the configuration and the parser state.
  byte_t            hdr_value;
  logic             deliver_on;
  parse_t           parse_ph;
  logic [5:0]       taken_cnt;
  byte_t            len_field;
  byte_t            xor_acc;
  byte_t            type_hold;
  logic [CMD_W-1:0] cmd_hold;
  byte_t            payload_mem [0:MAX_PAYLOAD-1];

  frame_item_t expected_items [$];

  int          fail_count    = 0;
  int          frame_bytes   = 0;
  int          rx_gap_pct    = 0;
  int          res_stall_pct = 0;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;

  // Advance the predictor by one accepted byte and queue any frame it completes.
  task automatic predict_byte(input byte_t b);
    frame_item_t it;
    int          plen;
    case (parse_ph)
      PARSE_LEN: begin
        len_field = b;
        taken_cnt = '0;
        xor_acc   = b;
        parse_ph  = (b < MIN_LEN || b > MAX_LEN) ? PARSE_HUNT : PARSE_DATA;
      end
      PARSE_DATA: begin
        if (taken_cnt >= len_field) begin
          // This is the check byte; the frame closes either way.
          parse_ph = PARSE_HUNT;
          if (b == xor_acc && deliver_on) begin
            plen = len_field - MIN_LEN;
            for (int k = 0; k < ((plen == 0) ? 1 : plen); k++) begin
              it.frame_type    = type_hold;
              it.command       = cmd_hold;
              it.payload_len   = PLEN_W'(plen);
              it.has_payload   = (plen != 0);
              it.payload_index = PIDX_W'(k);
              it.payload_byte  = (plen != 0) ? payload_mem[k] : '0;
              it.last          = (plen == 0) || (k == plen - 1);
              expected_items.push_back(it);
            end
          end
        end else begin
          case (taken_cnt)
            6'd0:    type_hold = b;
            6'd1:    cmd_hold[15:8] = b;
            6'd2:    cmd_hold[7:0] = b;
            default: payload_mem[taken_cnt - MIN_LEN] = b;
          endcase
          xor_acc   = xor_acc ^ b;
          taken_cnt = taken_cnt + 1'b1;
        end
      end
      default: begin
        parse_ph = (b == hdr_value) ? PARSE_LEN : PARSE_HUNT;
      end
    endcase
  endtask

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_byte(input byte_t b);
    if ($urandom_range(99) < rx_gap_pct) begin
      rx_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < rx_gap_pct);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    predict_byte(b);
  endtask

  // Send header, length, data bytes and a check byte that is right or deliberately wrong.
  task automatic send_frame(input byte_t len, input fill_t fill, input bit bad_check);
    byte_t chk;
    byte_t b;
    byte_t flip;
    chk = len;
    send_byte(hdr_value);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = '0;
        FILL_ONES: b = '1;
        default:   b = $urandom;
      endcase
      chk = chk ^ b;
      send_byte(b);
    end
    if (bad_check) begin
      flip = $urandom_range(255, 1);
      chk  = chk ^ flip;
    end
    send_byte(chk);
    frame_bytes += len + 3;
  endtask

  // Feed filler bytes until the parser is back to hunting, never completing a good frame.
  task automatic flush_parser;
    while (parse_ph != PARSE_HUNT) begin
      send_byte((parse_ph == PARSE_DATA && taken_cnt >= len_field) ? ~xor_acc : 8'h00);
    end
  endtask

  // Bring the block to rest: parser hunting, every result delivered, pipeline settled.
  task automatic wait_idle;
    flush_parser();
    rx_ch.valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one configuration register; the caller makes sure the block is idle.
  task automatic cfg_write(input cfg_reg_t idx, input byte_t data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_HEADER) begin
      hdr_value = data;
    end else begin
      deliver_on = data[0];
    end
    @(posedge clk);
  endtask

  task automatic set_idling(input int gap_pct, input int stall_pct);
    rx_gap_pct    = gap_pct;
    res_stall_pct = stall_pct;
  endtask

  // Mostly well-formed frames with random content, plus bad lengths, cut frames and noise.
  task automatic random_traffic(input int n_bytes);
    int    goal;
    int    pick;
    int    sel;
    int    plen;
    int    cut;
    byte_t b;
    goal = frame_bytes + n_bytes;
    while (frame_bytes < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        sel  = $urandom_range(99);
        plen = (sel < 60) ? $urandom_range(4) :
               (sel < 90) ? $urandom_range(16, 5) : $urandom_range(MAX_PAYLOAD, 17);
        send_frame(MIN_LEN + plen, FILL_RANDOM, $urandom_range(9) == 0);
      end else if (pick < 80) begin
        // Header followed by a length outside the legal range.
        b = $urandom_range(1) ? $urandom_range(MIN_LEN - 1) : $urandom_range(255, MAX_LEN + 1);
        send_byte(hdr_value);
        send_byte(b);
        frame_bytes += 2;
      end else if (pick < 88) begin
        // A frame cut short; half the time the next bytes land inside it.
        plen = $urandom_range(8);
        cut  = $urandom_range(MIN_LEN + plen - 1);
        send_byte(hdr_value);
        send_byte(MIN_LEN + plen);
        for (int i = 0; i < cut; i++) begin
          b = $urandom;
          send_byte(b);
        end
        frame_bytes += cut + 2;
        if ($urandom_range(1)) flush_parser();
      end else begin
        // Line noise between frames.
        repeat ($urandom_range(6, 1)) begin
          b = $urandom;
          send_byte(b);
        end
        if ($urandom_range(3) != 0) flush_parser();
      end
    end
  endtask

  // After reset delivery is off, so a good frame gives nothing until it is enabled.
  task automatic test_reset_defaults;
    set_idling(0, 0);
    send_frame(MIN_LEN + 2, FILL_RANDOM, 0);
    wait_idle();
    cfg_write(CFG_DELIVER, 8'h01);
    send_frame(MIN_LEN + 2, FILL_RANDOM, 0);
  endtask

  // Field extremes, empty payload, bad lengths, check mismatch and the largest payload.
  task automatic test_directed_cases;
    set_idling(0, 0);
    send_frame(MIN_LEN, FILL_ONES, 0);
    send_frame(MIN_LEN + 1, FILL_ZERO, 0);
    send_byte(hdr_value);
    send_byte(MIN_LEN - 1);
    send_byte(hdr_value);
    send_byte(8'h00);
    // A header value as the length is rejected and must not restart a frame.
    send_byte(hdr_value);
    send_byte(hdr_value);
    send_frame(MIN_LEN, FILL_RANDOM, 0);
    send_byte(hdr_value);
    send_byte(MAX_LEN + 1);
    send_frame(MIN_LEN + 2, FILL_RANDOM, 1);
    send_frame(MAX_LEN, FILL_ONES, 0);
    send_frame(MAX_LEN, FILL_RANDOM, 0);
  endtask

  // Random traffic under each flow-control pattern.
  task automatic test_idle_phases;
    set_idling(0, 0);
    random_traffic(40);
    set_idling(72, 0);
    random_traffic(40);
    set_idling(0, 72);
    random_traffic(40);
    set_idling(17, 17);
    random_traffic(40);
  endtask

  // Header at both extremes and a random value, delivery toggled off and on.
  task automatic test_config_sweep;
    byte_t hdr;
    set_idling(17, 17);
    wait_idle();
    cfg_write(CFG_HEADER, 8'h00);
    random_traffic(20);
    wait_idle();
    cfg_write(CFG_HEADER, 8'hFF);
    cfg_write(CFG_DELIVER, 8'h00);
    random_traffic(20);
    wait_idle();
    hdr = $urandom;
    cfg_write(CFG_HEADER, hdr);
    cfg_write(CFG_DELIVER, 8'h01);
    random_traffic(20);
    wait_idle();
    cfg_write(CFG_HEADER, HEADER_RESET);
  endtask

  // Results are held off for a long stretch while items keep coming.
  task automatic test_backpressure;
    set_idling(0, 0);
    wait_idle();
    @(negedge clk);
    hold_asked = hold_asked + 1;
    @(posedge clk);
    send_frame(MAX_LEN, FILL_RANDOM, 0);
    send_frame(MIN_LEN + 5, FILL_RANDOM, 0);
    send_frame(MIN_LEN, FILL_RANDOM, 0);
  endtask

  // Result-side ready: random stalls, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_served  <= hold_served + 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Compare each delivered result with the oldest pending expectation.
  always @(posedge clk) begin : result_check
    frame_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_items.size() == 0) begin
        $error("result item with nothing expected: type 0x%0h index %0d",
               res_ch.frame_type, res_ch.payload_index);
        fail_count++;
      end else begin
        want = expected_items.pop_front();
        check_field("frame_type", want.frame_type, res_ch.frame_type);
        check_field("command", want.command, res_ch.command);
        check_field("payload_len", want.payload_len, res_ch.payload_len);
        check_field("has_payload", want.has_payload, res_ch.has_payload);
        check_field("payload_index", want.payload_index, res_ch.payload_index);
        check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
        check_field("last", want.last, res_ch.last);
      end
    end
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("hex_frame_receiver_xor_check regression: fail");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = CFG_HEADER;
    cfg_ch.wdata     = '0;
    res_ch.ready     = 1'b0;
    hdr_value        = HEADER_RESET;
    deliver_on       = 1'b0;
    parse_ph         = PARSE_HUNT;
    taken_cnt        = '0;
    len_field        = '0;
    xor_acc          = '0;
    type_hold        = '0;
    cmd_hold         = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_idle_phases();
    test_config_sweep();
    test_backpressure();
    wait_idle();

    if (fail_count == 0) begin
      $display("hex_frame_receiver_xor_check regression: pass");
    end else begin
      $display("hex_frame_receiver_xor_check regression: fail");
    end
    $finish;
  end

endmodule
